[src/cursor_overlay_compositor_top_defines.svh]
// assertion macros used by the compositor checker
`ifndef CURSOR_OVERLAY_COMPOSITOR_TOP_DEFINES_SVH
`define CURSOR_OVERLAY_COMPOSITOR_TOP_DEFINES_SVH

// property checked on every clock while out of reset
`define COC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property that must also hold across reset
`define COC_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[src/coc_pkg.sv]
// shared types, constants and helpers of the cursor overlay compositor
`timescale 1ns / 1ps

package coc_pkg;

    localparam int SHAPE_WORDS_DEF = 4096;
    localparam int CMD_DEPTH_DEF   = 4;
    localparam int OUT_DEPTH_DEF   = 4;

    // byte address into the shape store and the word index derived from it
    localparam int BADDR_W = 21;
    localparam int WIDX_W  = BADDR_W - 2;

    localparam logic [31:0] ALPHA_OPAQUE = 32'hff00_0000;
    localparam logic [31:0] RGB_MASK     = 32'h00ff_ffff;
    localparam logic [7:0]  CH_MAX       = 8'd255;

    typedef enum logic {
        CMD_WRITE,
        CMD_PIXEL
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_X,
        CFG_Y,
        CFG_WIDTH,
        CFG_HEIGHT,
        CFG_PITCH,
        CFG_TYPE,
        CFG_VISIBLE
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SHAPE_MONO,
        SHAPE_COLOR,
        SHAPE_MASK,
        SHAPE_NONE
    } t_shape;

    typedef enum logic [2:0] {
        K_WRITE,
        K_PASS,
        K_MONO,
        K_COLOR,
        K_MASK
    } t_kind;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [6:0]  width;
        logic [7:0]  height;
        logic [10:0] pitch;
        t_shape      stype;
        logic        visible;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        x:       12'd0,
        y:       12'd0,
        width:   7'd0,
        height:  8'd0,
        pitch:   11'd0,
        stype:   SHAPE_NONE,
        visible: 1'b0
    };

    // classified request: data is the shape word for writes, the background otherwise
    typedef struct packed {
        t_kind       kind;
        logic [11:0] addr;
        logic [31:0] data;
        logic [6:0]  dx;
        logic [7:0]  dy;
    } t_op;

    // floor(x / 255) for x up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

endpackage

[src/coc_fifo.sv]
// small synchronous fifo used for the command and result queues
`timescale 1ns / 1ps

module coc_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_buf[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (wr_en) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (rd_en) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        unique case ({wr_en, rd_en})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_buf[r_wptr] <= i_data;
        end
    end

endmodule

[src/coc_front.sv]
// front end: configuration registers and classification of incoming requests
`timescale 1ns / 1ps

module coc_front import coc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    output t_cfg        o_cfg,
    input  logic        i_push,
    input  logic        i_command,
    input  logic [11:0] i_shape_addr,
    input  logic [31:0] i_shape_word,
    input  logic [11:0] i_pixel_x,
    input  logic [11:0] i_pixel_y,
    input  logic [31:0] i_background,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_op         o_op
);

    t_cfg        r_cfg;
    logic [7:0]  h_eff;
    logic [11:0] dx_full;
    logic [11:0] dy_full;
    logic        in_rect;

    assign o_cfg       = r_cfg;
    assign o_cfg_ready = 1'b1;
    assign o_q_push    = i_push && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_X:       r_cfg.x       <= i_cfg_data;
                CFG_Y:       r_cfg.y       <= i_cfg_data;
                CFG_WIDTH:   r_cfg.width   <= i_cfg_data[6:0];
                CFG_HEIGHT:  r_cfg.height  <= i_cfg_data[7:0];
                CFG_PITCH:   r_cfg.pitch   <= i_cfg_data[10:0];
                CFG_TYPE:    r_cfg.stype   <= t_shape'(i_cfg_data[1:0]);
                CFG_VISIBLE: r_cfg.visible <= i_cfg_data[0];
                default:     r_cfg         <= r_cfg;
            endcase
        end
    end

    always_comb begin
        // monochrome shapes stack the and plane over the xor plane
        h_eff   = (r_cfg.stype == SHAPE_MONO) ? {1'b0, r_cfg.height[7:1]} : r_cfg.height;
        dx_full = i_pixel_x - r_cfg.x;
        dy_full = i_pixel_y - r_cfg.y;
        in_rect = (i_pixel_x >= r_cfg.x) && (i_pixel_y >= r_cfg.y)
                  && (dx_full < {5'd0, r_cfg.width}) && (dy_full < {4'd0, h_eff});

        o_op.addr = i_shape_addr;
        o_op.data = (i_command == CMD_PIXEL) ? i_background : i_shape_word;
        o_op.dx   = dx_full[6:0];
        o_op.dy   = dy_full[7:0];

        if (i_command == CMD_WRITE) begin
            o_op.kind = K_WRITE;
        end else if (!r_cfg.visible || !in_rect) begin
            o_op.kind = K_PASS;
        end else begin
            unique case (r_cfg.stype)
                SHAPE_MONO:  o_op.kind = K_MONO;
                SHAPE_COLOR: o_op.kind = K_COLOR;
                SHAPE_MASK:  o_op.kind = K_MASK;
                default:     o_op.kind = K_PASS;
            endcase
        end
    end

endmodule

[src/coc_back.sv]
// back end: shape store, address pipeline, shape fetch and pixel compositing
`timescale 1ns / 1ps

module coc_back import coc_pkg::*; #(
    parameter int SHAPE_WORDS = SHAPE_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_op         i_q_op,
    input  logic        i_q_empty,
    output logic        o_q_pop,
    input  logic        i_out_full,
    output logic        o_out_push,
    output logic [31:0] o_out_data
);

    localparam int AW = (SHAPE_WORDS > 1) ? $clog2(SHAPE_WORDS) : 1;

    logic adv;

    // stage 1: row offsets
    logic        r_v1;
    t_op         r_op1;
    logic [18:0] base1;
    logic [17:0] hoff1;

    // stage 2: byte addresses, store access
    logic               r_v2;
    t_op                r_op2;
    logic [18:0]        r_base2;
    logic [17:0]        r_hoff2;
    logic [BADDR_W-1:0] and_b;
    logic [BADDR_W-1:0] xor_b;
    logic [BADDR_W-1:0] pix_b;
    logic [WIDX_W-1:0]  widx_a;
    logic [WIDX_W-1:0]  widx_b;
    logic [1:0]         off_a;
    logic               ok_a;
    logic               ok_b;
    logic               wr_ok;
    logic [31:0]        r_shape [SHAPE_WORDS];

    // stage 3: shape data, per-mode result, blend products
    logic        r_v3;
    t_op         r_op3;
    logic [1:0]  r_off_a3;
    logic [1:0]  r_off_b3;
    logic        r_ok_a3;
    logic        r_ok_b3;
    logic [31:0] r_rd_a;
    logic [31:0] r_rd_b;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [4:0]  pos_a;
    logic [4:0]  pos_b;
    logic [63:0] pair;
    logic [31:0] shape;
    logic [7:0]  alpha_inv;
    logic [31:0] pix3;
    logic        blend3;

    // stage 4: channel sums and output
    logic        r_v4;
    logic        r_res4;
    logic        r_blend4;
    logic [31:0] r_pix4;
    logic [15:0] r_ps [3];
    logic [15:0] r_pd [3];
    logic [15:0] sum4 [3];

    assign adv     = !i_out_full;
    assign o_q_pop = adv && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v1 <= !i_q_empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // stage 1
    assign base1 = 19'(r_op1.dy) * 19'(i_cfg.pitch);
    assign hoff1 = 18'(i_cfg.height[7:1]) * 18'(i_cfg.pitch);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_op1   <= i_q_op;
            r_op2   <= r_op1;
            r_base2 <= base1;
            r_hoff2 <= hoff1;
        end
    end

    // stage 2
    always_comb begin
        and_b = BADDR_W'(r_base2) + BADDR_W'(r_op2.dx[6:3]);
        xor_b = and_b + BADDR_W'(r_hoff2);
        pix_b = BADDR_W'(r_base2) + BADDR_W'({r_op2.dx, 2'b00});
        if (r_op2.kind == K_MONO) begin
            widx_a = and_b[BADDR_W-1:2];
            widx_b = xor_b[BADDR_W-1:2];
            off_a  = and_b[1:0];
        end else begin
            // an unaligned color word spans this word and the next
            widx_a = pix_b[BADDR_W-1:2];
            widx_b = pix_b[BADDR_W-1:2] + WIDX_W'(1);
            off_a  = pix_b[1:0];
        end
        ok_a  = (32'(widx_a) < 32'(SHAPE_WORDS));
        ok_b  = (32'(widx_b) < 32'(SHAPE_WORDS));
        wr_ok = r_v2 && (r_op2.kind == K_WRITE) && (32'(r_op2.addr) < 32'(SHAPE_WORDS));
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (wr_ok) begin
                r_shape[AW'(r_op2.addr)] <= r_op2.data;
            end
            r_rd_a <= r_shape[AW'(widx_a)];
            r_rd_b <= r_shape[AW'(widx_b)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_op3    <= r_op2;
            r_off_a3 <= off_a;
            r_off_b3 <= xor_b[1:0];
            r_ok_a3  <= ok_a;
            r_ok_b3  <= ok_b;
        end
    end

    // stage 3
    always_comb begin
        word_a    = r_ok_a3 ? r_rd_a : '0;
        word_b    = r_ok_b3 ? r_rd_b : '0;
        pos_a     = {r_off_a3, 3'b111 - r_op3.dx[2:0]};
        pos_b     = {r_off_b3, 3'b111 - r_op3.dx[2:0]};
        pair      = {word_b, word_a} >> {r_off_a3, 3'b000};
        shape     = pair[31:0];
        alpha_inv = CH_MAX - shape[31:24];
        blend3    = 1'b0;
        pix3      = r_op3.data;
        unique case (r_op3.kind)
            K_MONO: begin
                if (!word_a[pos_a]) begin
                    pix3 = ALPHA_OPAQUE;
                end
                if (word_b[pos_b]) begin
                    pix3 = (pix3 ^ RGB_MASK) | ALPHA_OPAQUE;
                end
            end
            K_MASK: begin
                pix3 = (shape[31:24] != 8'd0) ? ((r_op3.data ^ shape) | ALPHA_OPAQUE)
                                              : (shape | ALPHA_OPAQUE);
            end
            K_COLOR: begin
                blend3 = (shape[31:24] != 8'd0);
            end
            default: begin
                pix3 = r_op3.data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res4   <= (r_op3.kind != K_WRITE);
            r_blend4 <= blend3;
            r_pix4   <= pix3;
            for (int c = 0; c < 3; c++) begin
                r_ps[c] <= 16'(shape[8*c +: 8]) * 16'(shape[31:24]);
                r_pd[c] <= 16'(r_op3.data[8*c +: 8]) * 16'(alpha_inv);
            end
        end
    end

    // stage 4
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sum4[c] = r_ps[c] + r_pd[c];
        end
        o_out_data = r_blend4 ? {8'hff, div255(sum4[2]), div255(sum4[1]), div255(sum4[0])}
                              : r_pix4;
    end

    assign o_out_push = adv && r_v4 && r_res4;

endmodule

[src/cursor_overlay_compositor_top.sv]
// top level of the cursor overlay compositor.
// Takes one request per clock: a shape word write or a frame pixel, and returns one
// composited ARGB pixel per pixel request, in order. Throughput is one request per
// cycle as long as results are popped. A pixel passes through the command queue, the
// four-stage back pipeline (row offset multiply, shape store access through two read
// ports, byte select with blend multiplies, channel sum and divide by 255) and the
// result queue. A full result queue stalls the back pipeline and the command queue
// then fills, raising full. Shape words that were never written read back as arbitrary
// data; there is no clearing pass. Register writes are taken at once and must only be
// made while no request is in flight.
`timescale 1ns / 1ps

module cursor_overlay_compositor_top import coc_pkg::*; #(
    parameter int SHAPE_WORDS = SHAPE_WORDS_DEF,
    parameter int CMD_DEPTH   = CMD_DEPTH_DEF,
    parameter int OUT_DEPTH   = OUT_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_command,
    input  logic [11:0] i_shape_addr,
    input  logic [31:0] i_shape_word,
    input  logic [11:0] i_pixel_x,
    input  logic [11:0] i_pixel_y,
    input  logic [31:0] i_background,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_pixel_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    t_cfg        cfg;
    t_op         q_in;
    t_op         q_out;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    logic        out_push;
    logic        out_full;
    logic [31:0] out_data;

    assign full = q_full;

    coc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_cfg        (cfg),
        .i_push       (push),
        .i_command    (i_command),
        .i_shape_addr (i_shape_addr),
        .i_shape_word (i_shape_word),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .i_background (i_background),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_op         (q_in)
    );

    coc_fifo #(
        .WIDTH ($bits(t_op)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    coc_back #(
        .SHAPE_WORDS (SHAPE_WORDS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_q_op     (q_out),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .i_out_full (out_full),
        .o_out_push (out_push),
        .o_out_data (out_data)
    );

    coc_fifo #(
        .WIDTH (32),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_data),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (o_pixel_out),
        .o_empty (empty)
    );

endmodule

[src/coc_checker.sv]
// port-level checker for the compositor and its bind to the top level
`timescale 1ns / 1ps
`include "cursor_overlay_compositor_top_defines.svh"

module coc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [31:0] o_pixel_out
);

    // reset leaves both queues empty
    `COC_ASSERT_ANY(a_reset_clears, !i_rst_n |=> empty && !full, "queues not cleared by reset")

    // a waiting result holds until popped
    `COC_ASSERT(a_result_holds, !empty && !pop |=> !empty && $stable(o_pixel_out), "result changed while waiting")

    // the command queue only fills from an accepted request
    `COC_ASSERT(a_full_needs_push, $rose(full) |-> $past(push), "full rose without a request")

    // after reset, no result reaches the output until one has passed the queues and back pipeline
    `COC_ASSERT(a_no_early_result, $fell(empty) |-> $past(i_rst_n) && $past(i_rst_n, 2) && $past(i_rst_n, 3), "result appeared too soon after reset")

endmodule

bind cursor_overlay_compositor_top coc_checker u_coc_checker (.*);
